[src/sism_pkg.sv]
`timescale 1ns / 1ps

package sism_pkg;

	// Default geometry: both must be powers of two.
	localparam int DEF_MAP_ENTRIES     = 4096;
	localparam int DEF_CLUSTER_SECTORS = 4096;

	localparam int SECT_W = 24;
	localparam int CNT_W  = 16;
	localparam int PHYS_W = 25;
	localparam int LEN_W  = 13;
	localparam int SLOT_W = 12;
	localparam int FREE_W = 13;

	localparam logic [SECT_W-1:0] DATA_BASE_RST = 24'd8193;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_SEG,
		BK_LOOK
	} back_state_t;

	typedef struct packed {
		logic              is_write;
		status_t           status;
		logic [SECT_W-1:0] start;
		logic [CNT_W-1:0]  count;
	} cmd_t;

	typedef struct packed {
		logic vld;
		cmd_t cmd;
	} cmd_head_t;

	typedef struct packed {
		logic              vld;
		logic [SLOT_W-1:0] slot;
	} map_ent_t;

endpackage

[src/sism_front.sv]
`timescale 1ns / 1ps

module sism_front #(
	parameter int MAP_ENTRIES     = sism_pkg::DEF_MAP_ENTRIES,
	parameter int CLUSTER_SECTORS = sism_pkg::DEF_CLUSTER_SECTORS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic                          req_type,
	input  logic [sism_pkg::SECT_W-1:0]   start_sector,
	input  logic [sism_pkg::CNT_W-1:0]    sector_count,
	input  logic                          accept_en,
	output sism_pkg::cmd_head_t           head,
	input  logic                          pop
);
	import sism_pkg::*;

	localparam int SPACE_SH = $clog2(MAP_ENTRIES) + $clog2(CLUSTER_SECTORS);

	logic [PHYS_W-1:0] end_m1;
	logic              beyond;
	cmd_t              cmd_in;
	logic              push;

	cmd_t              q_mem [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        cnt_q;

	// The request runs past the end of the virtual space when its last sector
	// has any bit set at or above the space size.
	always_comb begin
		end_m1 = PHYS_W'(start_sector) + PHYS_W'(sector_count) - PHYS_W'(1);
		beyond = |(end_m1 >> SPACE_SH);
		cmd_in.is_write = req_type;
		cmd_in.start    = start_sector;
		cmd_in.count    = sector_count;
		if (sector_count == '0) begin
			cmd_in.status = ST_EMPTY;
		end else if (beyond) begin
			cmd_in.status = ST_RANGE;
		end else begin
			cmd_in.status = ST_OK;
		end
	end

	assign req_ready = accept_en && (cnt_q != 2'd2);
	assign push      = req_valid && req_ready;
	assign head.vld  = (cnt_q != 2'd0);
	assign head.cmd  = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[src/sism_back.sv]
`timescale 1ns / 1ps

module sism_back #(
	parameter int MAP_ENTRIES     = sism_pkg::DEF_MAP_ENTRIES,
	parameter int CLUSTER_SECTORS = sism_pkg::DEF_CLUSTER_SECTORS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [sism_pkg::SECT_W-1:0]   data_base,
	input  sism_pkg::cmd_head_t           head,
	output logic                          pop,
	output logic                          accept_en,
	output logic                          seg_valid,
	input  logic                          seg_ready,
	output logic [sism_pkg::PHYS_W-1:0]   phys_sector,
	output logic [sism_pkg::LEN_W-1:0]    seg_length,
	output logic                          zero_fill,
	output logic                          new_cluster,
	output logic [1:0]                    status,
	output logic                          last
);
	import sism_pkg::*;

	localparam int IDX_W = $clog2(MAP_ENTRIES);
	localparam int OFF_W = $clog2(CLUSTER_SECTORS);
	localparam int SH_W  = SLOT_W + OFF_W;

	back_state_t        state_q, state_d;

	logic [IDX_W-1:0]   clr_idx_q;
	logic [PHYS_W-1:0]  pos_q;
	logic [CNT_W-1:0]   rem_q;
	logic               wr_q;
	logic [FREE_W-1:0]  free_q;

	logic [IDX_W-1:0]   idx_s1;
	logic [OFF_W-1:0]   off_s1;
	logic [CNT_W-1:0]   len_s1;
	map_ent_t           rd_s1;

	map_ent_t           map_mem [MAP_ENTRIES];

	logic               mem_we, mem_re;
	logic [IDX_W-1:0]   mem_waddr;
	map_ent_t           mem_wdata;

	logic [IDX_W-1:0]   cl;
	logic [OFF_W-1:0]   off;
	logic [OFF_W:0]     room;
	logic [CNT_W-1:0]   len;

	logic               out_free;
	logic               alloc;
	logic               mapped;
	logic [SLOT_W-1:0]  slot;
	logic [SH_W-1:0]    slot_sh;
	logic [PHYS_W-1:0]  phys;
	logic [CNT_W-1:0]   rem_next;
	logic               seg_last;

	logic               start_cmd, load_spec, adv;

	logic               seg_valid_q;
	logic [PHYS_W-1:0]  phys_q;
	logic [LEN_W-1:0]   len_q;
	logic               zf_q, nc_q, last_q;
	status_t            status_q;

	// Split point for the segment starting at pos_q.
	always_comb begin
		cl   = IDX_W'(pos_q >> OFF_W);
		off  = pos_q[OFF_W-1:0];
		room = (OFF_W+1)'(CLUSTER_SECTORS) - (OFF_W+1)'(off);
		len  = (17'(room) < 17'(rem_q)) ? CNT_W'(room) : rem_q;
	end

	// Map lookup result and the physical address of the segment.
	always_comb begin
		out_free = !seg_valid_q || seg_ready;
		alloc    = !rd_s1.vld && wr_q;
		mapped   = rd_s1.vld || wr_q;
		slot     = alloc ? SLOT_W'(free_q) : rd_s1.slot;
		slot_sh  = {slot, {OFF_W{1'b0}}};
		phys     = mapped ? (PHYS_W'(data_base) + PHYS_W'(slot_sh) + PHYS_W'(off_s1))
		                  : '0;
		rem_next = rem_q - len_s1;
		seg_last = (rem_next == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		start_cmd = 1'b0;
		load_spec = 1'b0;
		adv       = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = '{vld: 1'b1, slot: slot};
		case (state_q)
			BK_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_idx_q;
				mem_wdata = '0;
				if (clr_idx_q == IDX_W'(MAP_ENTRIES - 1)) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (head.vld) begin
					if (head.cmd.status != ST_OK) begin
						if (out_free) begin
							load_spec = 1'b1;
							pop       = 1'b1;
						end
					end else begin
						start_cmd = 1'b1;
						pop       = 1'b1;
						state_d   = BK_SEG;
					end
				end
			end
			BK_SEG: begin
				mem_re  = 1'b1;
				state_d = BK_LOOK;
			end
			BK_LOOK: begin
				if (out_free) begin
					adv     = 1'b1;
					mem_we  = alloc;
					state_d = seg_last ? BK_IDLE : BK_SEG;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_s1 <= map_mem[cl];
		end
	end

	always_ff @(posedge clk) begin
		if (start_cmd) begin
			pos_q <= PHYS_W'(head.cmd.start);
			rem_q <= head.cmd.count;
			wr_q  <= head.cmd.is_write;
		end else if (adv) begin
			pos_q <= pos_q + PHYS_W'(len_s1);
			rem_q <= rem_next;
		end
		if (mem_re) begin
			idx_s1 <= cl;
			off_s1 <= off;
			len_s1 <= len;
		end
		if (load_spec) begin
			phys_q   <= '0;
			len_q    <= '0;
			zf_q     <= 1'b0;
			nc_q     <= 1'b0;
			status_q <= head.cmd.status;
			last_q   <= 1'b1;
		end else if (adv) begin
			phys_q   <= phys;
			len_q    <= LEN_W'(len_s1);
			zf_q     <= !mapped;
			nc_q     <= alloc;
			status_q <= ST_OK;
			last_q   <= seg_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q   <= '0;
			free_q      <= '0;
			seg_valid_q <= 1'b0;
		end else begin
			if (state_q == BK_CLEAR) begin
				clr_idx_q <= clr_idx_q + IDX_W'(1);
			end
			if (adv && alloc) begin
				free_q <= free_q + FREE_W'(1);
			end
			if (load_spec || adv) begin
				seg_valid_q <= 1'b1;
			end else if (seg_ready) begin
				seg_valid_q <= 1'b0;
			end
		end
	end

	assign accept_en   = (state_q != BK_CLEAR);
	assign seg_valid   = seg_valid_q;
	assign phys_sector = phys_q;
	assign seg_length  = len_q;
	assign zero_fill   = zf_q;
	assign new_cluster = nc_q;
	assign status      = status_q;
	assign last        = last_q;

`ifndef SYNTHESIS
	a_pop_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.vld)
		else $error("command popped from an empty queue");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("map read and write in the same cycle");

	a_seg_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_SEG) |-> (rem_q != '0))
		else $error("segment started with nothing left");

	a_free_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && alloc) |=> (free_q == $past(free_q) + FREE_W'(1)))
		else $error("free slot counter did not advance on allocation");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(load_spec || adv) |-> (!seg_valid_q || seg_ready))
		else $error("output register overwritten before being taken");
`endif

endmodule

[src/sparse_image_sector_mapper.sv]
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// req       req_valid/req_ready    req_type, start_sector, sector_count
// seg       seg_valid/seg_ready    phys_sector, seg_length, zero_fill, new_cluster,
//                                  status, last
// cfg       cfg_wr_en              cfg_wr_data (data_base_sector)
//
// Each cluster segment is a map read in BK_SEG and then, in BK_LOOK, the lookup, any
// allocation write-back and the output load, as the map has a single port. A request is
// taken off the queue in BK_IDLE; an empty or out-of-range request is taken and loaded
// into the output without leaving BK_IDLE. After reset the map is cleared one entry a cycle,
// during which no request beat is taken. A two-entry command queue lets the front take
// requests while the back end works; the output register holds a beat while stalled.

module sparse_image_sector_mapper #(
	parameter int MAP_ENTRIES     = sism_pkg::DEF_MAP_ENTRIES,
	parameter int CLUSTER_SECTORS = sism_pkg::DEF_CLUSTER_SECTORS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [sism_pkg::SECT_W-1:0]   cfg_wr_data,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic                          req_type,
	input  logic [sism_pkg::SECT_W-1:0]   start_sector,
	input  logic [sism_pkg::CNT_W-1:0]    sector_count,
	output logic                          seg_valid,
	input  logic                          seg_ready,
	output logic [sism_pkg::PHYS_W-1:0]   phys_sector,
	output logic [sism_pkg::LEN_W-1:0]    seg_length,
	output logic                          zero_fill,
	output logic                          new_cluster,
	output logic [1:0]                    status,
	output logic                          last
);
	import sism_pkg::*;

	// Start sector of slot zero; the user writes it only while idle, not enforced.
	logic [SECT_W-1:0] data_base_q;
	cmd_head_t         head;
	logic              pop;
	logic              accept_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_base_q <= DATA_BASE_RST;
		end else if (cfg_wr_en) begin
			data_base_q <= cfg_wr_data;
		end
	end

	// The front classifies each request as empty, out of range or normal and queues it.
	sism_front #(
		.MAP_ENTRIES     (MAP_ENTRIES),
		.CLUSTER_SECTORS (CLUSTER_SECTORS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req_type     (req_type),
		.start_sector (start_sector),
		.sector_count (sector_count),
		.accept_en    (accept_en),
		.head         (head),
		.pop          (pop)
	);

	// The back end splits a queued request at cluster boundaries, looks each cluster up
	// in the map, allocates on writes and gives one beat per segment, or a status beat.
	sism_back #(
		.MAP_ENTRIES     (MAP_ENTRIES),
		.CLUSTER_SECTORS (CLUSTER_SECTORS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_base   (data_base_q),
		.head        (head),
		.pop         (pop),
		.accept_en   (accept_en),
		.seg_valid   (seg_valid),
		.seg_ready   (seg_ready),
		.phys_sector (phys_sector),
		.seg_length  (seg_length),
		.zero_fill   (zero_fill),
		.new_cluster (new_cluster),
		.status      (status),
		.last        (last)
	);

endmodule
